### src/lvua_pkg.sv
// Shared types and constants for the least-used vector allocator.
package lvua_pkg;

    // Field widths of the transaction payloads
    localparam int VEC_W     = 8;
    localparam int LVL_W     = 4;
    localparam int CNT_W     = 8;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 2;

    // Defaults for the top-level parameters
    localparam int DEF_VECTORS_PER_LEVEL = 16;
    localparam int DEF_NUM_VECTORS       = 256;

    // Usage counts saturate here
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_LEVEL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_LEVEL = 2'd1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_UNUSED = 2'd2
    } t_status;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FIN,
        S_REL,
        S_DONE
    } t_state;

endpackage

### src/lvua_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lvua_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/least_used_vector_allocator.sv
// Top level of the least-used interrupt vector allocator.
//
// Input channel (i_in_valid / o_in_ready) carries one request: allocate or
// release. Output channel (o_out_valid / i_out_ready) returns one result per
// request: chosen vector, its level and a status code. The configuration
// channel (i_cfg_valid / o_cfg_ready) writes top_level (index 0) and
// bottom_level (index 1); write it only while no request is in flight.
// An allocate walks levels top_level down to bottom_level, offsets upward,
// one usage counter per cycle through a single RAM read port and one shared
// compare unit; it stops early at the first zero count. The scan runs in
// S_SCAN, then S_FIN bumps the chosen counter unless it is saturated. A
// release of a held, in-range vector reads and rewrites its counter in
// S_REL. An empty level range, or a release that touches no counter, goes
// straight to S_DONE, where the result waits for the output register. One
// request is handled at a time; o_in_ready is high whenever the sequencer is
// idle, also while a result still waits in the output register. When the
// receiver stalls, the finished result holds in the output register and the
// next request may still enter.
// Reset clears all usage counts at once through per-entry valid bits, so
// the block is ready in the first cycle after reset.
module least_used_vector_allocator #(
    parameter int VECTORS_PER_LEVEL = lvua_pkg::DEF_VECTORS_PER_LEVEL,
    parameter int NUM_VECTORS       = lvua_pkg::DEF_NUM_VECTORS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_op,
    input  logic [lvua_pkg::VEC_W-1:0]     i_release_vector,
    input  logic                           i_holds_vector,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [lvua_pkg::VEC_W-1:0]     o_chosen_vector,
    output logic [lvua_pkg::LVL_W-1:0]     o_chosen_level,
    output logic [lvua_pkg::STAT_W-1:0]    o_status,
    // configuration channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lvua_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lvua_pkg::LVL_W-1:0]     i_cfg_data
);

    localparam int VW     = lvua_pkg::VEC_W;
    localparam int LW     = lvua_pkg::LVL_W;
    localparam int CW     = lvua_pkg::CNT_W;
    localparam int OFF_W  = $clog2(VECTORS_PER_LEVEL);
    localparam int ADDR_W = $clog2(NUM_VECTORS);

    localparam logic [VW-1:0]    VPL_V    = VW'(VECTORS_PER_LEVEL);
    localparam logic [VW:0]      NUMV_V   = (VW+1)'(NUM_VECTORS);
    localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(VECTORS_PER_LEVEL - 1);

    // Control state
    lvua_pkg::t_state r_state, n_state;
    logic [LW-1:0]    r_top, r_bot;
    logic             r_issue, n_issue;
    logic             r_s1_valid, n_s1_valid;
    logic             r_found, n_found;
    logic             r_out_valid;
    logic [NUM_VECTORS-1:0] r_vld;

    // Scan datapath
    logic [LW-1:0]    r_lvl, n_lvl;
    logic [OFF_W-1:0] r_off, n_off;
    logic [VW-1:0]    r_base, n_base;
    logic             r_s1_in, n_s1_in;
    logic [VW-1:0]    r_s1_vec, n_s1_vec;
    logic [LW-1:0]    r_s1_lvl, n_s1_lvl;
    logic [VW-1:0]    r_best_vec, n_best_vec;
    logic [LW-1:0]    r_best_lvl, n_best_lvl;
    logic [CW-1:0]    r_best_cnt, n_best_cnt;
    logic [VW-1:0]    r_rel_vec, n_rel_vec;
    logic             r_rd_vld;

    // Pending result and output register
    logic [VW-1:0]             r_res_vec, n_res_vec;
    logic [LW-1:0]             r_res_lvl, n_res_lvl;
    lvua_pkg::t_status         r_res_status, n_res_status;
    logic [VW-1:0]             r_out_vec;
    logic [LW-1:0]             r_out_lvl;
    lvua_pkg::t_status         r_out_status;

    // Combinational helpers
    logic              in_acc, cfg_acc, out_load;
    logic [VW-1:0]     issue_vec;
    logic              issue_in;
    logic              rel_in;
    logic [CW-1:0]     ram_q, rd_cnt;
    logic              cand_better;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [CW-1:0]     wr_data;

    assign in_acc   = i_in_valid && o_in_ready;
    assign cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign out_load = (r_state == lvua_pkg::S_DONE) && (!r_out_valid || i_out_ready);

    assign issue_vec   = r_base + VW'(r_off);
    assign issue_in    = {1'b0, issue_vec} < NUMV_V;
    assign rel_in      = {1'b0, i_release_vector} < NUMV_V;
    assign rd_cnt      = r_rd_vld ? ram_q : '0;
    assign cand_better = r_s1_valid && r_s1_in && (!r_found || (rd_cnt < r_best_cnt));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lvua_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (lvua_pkg::t_op'(i_op) == lvua_pkg::OP_ALLOC) begin
                        n_state = (r_bot > r_top) ? lvua_pkg::S_DONE : lvua_pkg::S_SCAN;
                    end else begin
                        n_state = (i_holds_vector && rel_in) ? lvua_pkg::S_REL
                                                             : lvua_pkg::S_DONE;
                    end
                end
            end
            lvua_pkg::S_SCAN: begin
                if (!r_issue && !r_s1_valid) begin
                    n_state = lvua_pkg::S_FIN;
                end
            end
            lvua_pkg::S_FIN:  n_state = lvua_pkg::S_DONE;
            lvua_pkg::S_REL:  n_state = lvua_pkg::S_DONE;
            lvua_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = lvua_pkg::S_IDLE;
                end
            end
            default: n_state = lvua_pkg::S_IDLE;
        endcase
    end

    // RAM port control
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_best_vec[ADDR_W-1:0];
        wr_data = r_best_cnt + CW'(1);
        rd_addr = issue_vec[ADDR_W-1:0];
        unique case (r_state)
            lvua_pkg::S_IDLE: rd_addr = i_release_vector[ADDR_W-1:0];
            lvua_pkg::S_FIN: begin
                wr_en = r_found && (r_best_cnt != lvua_pkg::CNT_MAX);
            end
            lvua_pkg::S_REL: begin
                wr_en   = (rd_cnt != '0);
                wr_addr = r_rel_vec[ADDR_W-1:0];
                wr_data = rd_cnt - CW'(1);
            end
            default: ;
        endcase
    end

    // Scan sequencer and shared compare unit
    always_comb begin
        n_lvl        = r_lvl;
        n_off        = r_off;
        n_base       = r_base;
        n_issue      = r_issue;
        n_s1_valid   = 1'b0;
        n_s1_in      = r_s1_in;
        n_s1_vec     = r_s1_vec;
        n_s1_lvl     = r_s1_lvl;
        n_found      = r_found;
        n_best_vec   = r_best_vec;
        n_best_lvl   = r_best_lvl;
        n_best_cnt   = r_best_cnt;
        n_rel_vec    = r_rel_vec;
        n_res_vec    = r_res_vec;
        n_res_lvl    = r_res_lvl;
        n_res_status = r_res_status;
        unique case (r_state)
            lvua_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_res_vec    = '0;
                    n_res_lvl    = '0;
                    n_res_status = lvua_pkg::ST_OK;
                    n_lvl        = r_top;
                    n_off        = '0;
                    n_base       = VW'(r_top) * VPL_V;
                    n_found      = 1'b0;
                    n_issue      = 1'b0;
                    n_rel_vec    = i_release_vector;
                    if (lvua_pkg::t_op'(i_op) == lvua_pkg::OP_ALLOC) begin
                        if (r_bot > r_top) begin
                            n_res_status = lvua_pkg::ST_EMPTY;
                        end else begin
                            n_issue = 1'b1;
                        end
                    end else if (i_holds_vector && !rel_in) begin
                        n_res_status = lvua_pkg::ST_UNUSED;
                    end
                end
            end
            lvua_pkg::S_SCAN: begin
                // issue stage: read one counter, step offset then level
                n_s1_valid = r_issue;
                n_s1_in    = issue_in;
                n_s1_vec   = issue_vec;
                n_s1_lvl   = r_lvl;
                if (r_issue) begin
                    if (r_off == OFF_LAST) begin
                        n_off = '0;
                        if (r_lvl == r_bot) begin
                            n_issue = 1'b0;
                        end else begin
                            n_lvl  = r_lvl - LW'(1);
                            n_base = r_base - VPL_V;
                        end
                    end else begin
                        n_off = r_off + OFF_W'(1);
                    end
                end
                // compare stage: keep the first strictly smaller count
                if (cand_better) begin
                    n_found    = 1'b1;
                    n_best_vec = r_s1_vec;
                    n_best_lvl = r_s1_lvl;
                    n_best_cnt = rd_cnt;
                    if (rd_cnt == '0) begin
                        n_issue = 1'b0;
                    end
                end
            end
            lvua_pkg::S_FIN: begin
                if (r_found) begin
                    n_res_vec    = r_best_vec;
                    n_res_lvl    = r_best_lvl;
                    n_res_status = lvua_pkg::ST_OK;
                end else begin
                    n_res_vec    = '0;
                    n_res_lvl    = '0;
                    n_res_status = lvua_pkg::ST_EMPTY;
                end
            end
            lvua_pkg::S_REL: begin
                n_res_status = (rd_cnt == '0) ? lvua_pkg::ST_UNUSED : lvua_pkg::ST_OK;
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lvua_pkg::S_IDLE;
            r_top       <= LW'(14);
            r_bot       <= LW'(3);
            r_issue     <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
        end else begin
            r_state    <= n_state;
            r_issue    <= n_issue;
            r_s1_valid <= n_s1_valid;
            r_found    <= n_found;
            // apply configuration writes; unknown indexes drop
            if (cfg_acc) begin
                unique case (i_cfg_index)
                    lvua_pkg::CFG_TOP_LEVEL:    r_top <= i_cfg_data;
                    lvua_pkg::CFG_BOTTOM_LEVEL: r_bot <= i_cfg_data;
                    default: ;
                endcase
            end
            // mark counters as written
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            // advance the output register
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_lvl        <= n_lvl;
        r_off        <= n_off;
        r_base       <= n_base;
        r_s1_in      <= n_s1_in;
        r_s1_vec     <= n_s1_vec;
        r_s1_lvl     <= n_s1_lvl;
        r_best_vec   <= n_best_vec;
        r_best_lvl   <= n_best_lvl;
        r_best_cnt   <= n_best_cnt;
        r_rel_vec    <= n_rel_vec;
        r_res_vec    <= n_res_vec;
        r_res_lvl    <= n_res_lvl;
        r_res_status <= n_res_status;
        r_rd_vld     <= r_vld[rd_addr];
        if (out_load) begin
            r_out_vec    <= r_res_vec;
            r_out_lvl    <= r_res_lvl;
            r_out_status <= r_res_status;
        end
    end

    // Usage counter store
    lvua_ram #(
        .WIDTH (CW),
        .DEPTH (NUM_VECTORS)
    ) u_cnt_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_q)
    );

    assign o_in_ready      = (r_state == lvua_pkg::S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_chosen_vector = r_out_vec;
    assign o_chosen_level  = r_out_lvl;
    assign o_status        = r_out_status;

endmodule

### src/lvua_chk.sv
// Port-level checker for the least-used vector allocator, with its bind.
module lvua_chk #(
    parameter int VECTORS_PER_LEVEL = lvua_pkg::DEF_VECTORS_PER_LEVEL
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [lvua_pkg::VEC_W-1:0]  o_chosen_vector,
    input logic [lvua_pkg::LVL_W-1:0]  o_chosen_level,
    input logic [lvua_pkg::STAT_W-1:0] o_status
);

    localparam int VW = lvua_pkg::VEC_W;

    logic [VW:0] lvl_lo;
    logic [VW:0] lvl_hi;

    assign lvl_lo = (VW+1)'(o_chosen_level) * (VW+1)'(VECTORS_PER_LEVEL);
    assign lvl_hi = lvl_lo + (VW+1)'(VECTORS_PER_LEVEL);

    // The sequencer is busy in the cycle after a request is accepted
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while the previous one was starting");

    // A stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_chosen_vector)
            && $stable(o_chosen_level) && $stable(o_status)))
        else $error("stalled result changed");

    // Error results carry no vector
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != lvua_pkg::ST_OK))
            |-> ((o_chosen_vector == '0) && (o_chosen_level == '0)))
        else $error("error result with nonzero vector or level");

    // The reported level is the level of the reported vector
    a_level_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == lvua_pkg::ST_OK))
            |-> (({1'b0, o_chosen_vector} >= lvl_lo) && ({1'b0, o_chosen_vector} < lvl_hi)))
        else $error("chosen level does not match chosen vector");

endmodule

bind least_used_vector_allocator lvua_chk #(
    .VECTORS_PER_LEVEL (VECTORS_PER_LEVEL)
) u_lvua_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_chosen_vector (o_chosen_vector),
    .o_chosen_level  (o_chosen_level),
    .o_status        (o_status)
);
